// ===== rtl/nav_pkg.sv =====
// Shared types, constants and codes for the node availability watchdog.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package nav_pkg;

    // Number of rows in the node table.
    localparam int NODES = 16;
    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam logic [7:0] NODES_LIMIT = 8'(NODES);

    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 8;
    localparam int FRAME_W  = 32;
    localparam int MISS_W   = 16;
    localparam int TOTAL_W  = 8;
    localparam int STATE_W  = 2;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;

    localparam logic [MISS_W-1:0] THRESHOLD_RESET = 16'd3;

    // Commands carried on the input channel.
    localparam logic [CMD_W-1:0] CMD_EVALUATE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ONE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MARK_ALL  = 2'd2;

    // Availability codes.
    localparam logic [STATE_W-1:0] AV_UNKNOWN = 2'd0;
    localparam logic [STATE_W-1:0] AV_ONLINE  = 2'd1;
    localparam logic [STATE_W-1:0] AV_OFFLINE = 2'd2;

    typedef enum logic {
        CTL_IDLE,
        CTL_EXEC
    } ctl_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
    } ctl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// ===== rtl/node_availability_watchdog.sv =====
// Node availability watchdog: top level joining controller and datapath.
// Depends on nav_pkg, nav_ctrl and nav_dpath.
//
// Usage: each input transaction on the s_ channel carries a command in
// s_tuser and the node fields in s_tdata. Evaluate updates one node row
// (online on a new frame, offline when missed polls reach the threshold),
// clear drops one row's pending mark, and mark-all sets the pending mark on
// every row whose state is known. Each input transaction produces exactly
// one result transaction on the m_ channel with the change report, the
// addressed row after the step and the online and watched totals.
// The miss threshold is written through cfg_wen/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Flow: a transaction accepted in the idle state is loaded into the input
// register; the controller then holds in its exec state until the output
// register is free and runs the single table read-modify-write, loading the
// output register. A new item is accepted only once back in idle. Totals
// are kept as running counts that move only with the addressed row.
// When the receiver stalls, the result waits in the output register; one
// more item may be taken and is held until that register frees up.
// Reset (aresetn low, synchronous) clears every row to unknown, all flags
// and totals to zero, and the threshold to 3. There is no clearing pass.
module node_availability_watchdog (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input channel.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // node_index[7:0], deployed[8], heard[9], frame_count[41:10],
    // miss_count[57:42], zero[63:58]
    input  logic [nav_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd[1:0]
    input  logic [nav_pkg::CMD_W-1:0]          s_tuser,
    // Result channel.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // changed[0], from_state[2:1], to_state[4:3], node_state[6:5],
    // node_watched[7], node_pending[8], online_total[16:9],
    // watched_total[24:17], zero[31:25]
    output logic [nav_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Threshold register write port.
    input  logic                               cfg_wen,
    input  logic [nav_pkg::MISS_W-1:0]         cfg_wdata
);

    nav_pkg::ctl_cmd_t   ctl_cmd;
    nav_pkg::dp_status_t dp_status;

    nav_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    nav_dpath u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (ctl_cmd),
        .status    (dp_status)
    );

endmodule

// ===== rtl/nav_ctrl.sv =====
// Controller state machine for the node availability watchdog.
// Depends on nav_pkg for the state type and the command/status structs.
module nav_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  nav_pkg::dp_status_t status,
    output nav_pkg::ctl_cmd_t   cmd
);

    nav_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nav_pkg::CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nav_pkg::CTL_IDLE: begin
                if (s_tvalid) begin
                    state_next = nav_pkg::CTL_EXEC;
                end
            end
            nav_pkg::CTL_EXEC: begin
                if (!status.out_busy) begin
                    state_next = nav_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = nav_pkg::CTL_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            nav_pkg::CTL_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            nav_pkg::CTL_EXEC: begin
                cmd.exec = !status.out_busy;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/nav_dpath.sv =====
// Datapath of the node availability watchdog: input register, node table,
// running totals, threshold register and output register. Depends on nav_pkg.
module nav_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [nav_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [nav_pkg::CMD_W-1:0]          s_tuser,
    input  logic                               cfg_wen,
    input  logic [nav_pkg::MISS_W-1:0]         cfg_wdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [nav_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  nav_pkg::ctl_cmd_t                  cmd,
    output nav_pkg::dp_status_t                status
);

    // Latched transaction.
    logic [nav_pkg::CMD_W-1:0]   in_cmd_reg;
    logic [nav_pkg::INDEX_W-1:0] in_index_reg;
    logic                        in_deployed_reg;
    logic                        in_heard_reg;
    logic [nav_pkg::FRAME_W-1:0] in_frame_reg;
    logic [nav_pkg::MISS_W-1:0]  in_missed_reg;

    logic [nav_pkg::MISS_W-1:0]  thr_reg;

    // Node table.
    logic [nav_pkg::STATE_W-1:0] state_reg   [nav_pkg::NODES];
    logic [nav_pkg::STATE_W-1:0] state_next  [nav_pkg::NODES];
    logic                        seen_reg    [nav_pkg::NODES];
    logic                        seen_next   [nav_pkg::NODES];
    logic                        watch_reg   [nav_pkg::NODES];
    logic                        watch_next  [nav_pkg::NODES];
    logic                        pend_reg    [nav_pkg::NODES];
    logic                        pend_next   [nav_pkg::NODES];
    logic [nav_pkg::FRAME_W-1:0] lfc_reg     [nav_pkg::NODES];
    logic [nav_pkg::FRAME_W-1:0] lfc_next    [nav_pkg::NODES];

    logic [nav_pkg::TOTAL_W-1:0] online_reg, online_next;
    logic [nav_pkg::TOTAL_W-1:0] watched_reg, watched_next;

    logic                            out_valid_reg;
    logic [nav_pkg::OUT_DATA_W-1:0]  out_data_reg;

    logic [nav_pkg::IDX_W-1:0]   row;
    logic                        in_range;
    logic [nav_pkg::STATE_W-1:0] cur_state;
    logic [nav_pkg::STATE_W-1:0] new_state;
    logic [nav_pkg::MISS_W-1:0]  thr_eff;
    logic                        frame_new;
    logic                        do_eval;
    logic                        do_clear;
    logic                        do_mark;
    logic                        changed;
    logic                        w_before, w_after;
    logic                        on_before, on_after;
    logic [nav_pkg::STATE_W-1:0] row_state;
    logic                        row_watch;
    logic                        row_pend;

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_cmd_reg      <= s_tuser;
            in_index_reg    <= s_tdata[7:0];
            in_deployed_reg <= s_tdata[8];
            in_heard_reg    <= s_tdata[9];
            in_frame_reg    <= s_tdata[41:10];
            in_missed_reg   <= s_tdata[57:42];
        end
    end

    assign row      = in_index_reg[nav_pkg::IDX_W-1:0];
    assign in_range = in_index_reg < nav_pkg::NODES_LIMIT;
    assign cur_state = state_reg[row];
    assign thr_eff  = (thr_reg == '0) ? nav_pkg::MISS_W'(1) : thr_reg;
    assign frame_new = in_heard_reg && (!seen_reg[row] || in_frame_reg != lfc_reg[row]);

    always_comb begin
        new_state = cur_state;
        if (frame_new) begin
            new_state = nav_pkg::AV_ONLINE;
        end
        if (in_missed_reg >= thr_eff) begin
            new_state = nav_pkg::AV_OFFLINE;
        end
    end

    assign do_eval  = cmd.exec && in_range && (in_cmd_reg == nav_pkg::CMD_EVALUATE);
    assign do_clear = cmd.exec && in_range && (in_cmd_reg == nav_pkg::CMD_CLEAR_ONE);
    assign do_mark  = cmd.exec && (in_cmd_reg == nav_pkg::CMD_MARK_ALL);
    assign changed  = do_eval && (new_state != cur_state);

    always_comb begin
        for (int k = 0; k < nav_pkg::NODES; k++) begin
            state_next[k] = state_reg[k];
            seen_next[k]  = seen_reg[k];
            watch_next[k] = watch_reg[k];
            pend_next[k]  = pend_reg[k];
            lfc_next[k]   = lfc_reg[k];
            if (nav_pkg::IDX_W'(k) == row) begin
                if (do_eval) begin
                    if (in_heard_reg) begin
                        seen_next[k] = 1'b1;
                        lfc_next[k]  = in_frame_reg;
                    end
                    if (in_deployed_reg || in_heard_reg) begin
                        watch_next[k] = 1'b1;
                    end
                    if (changed) begin
                        state_next[k] = new_state;
                        pend_next[k]  = 1'b1;
                    end
                end
                if (do_clear) begin
                    pend_next[k] = 1'b0;
                end
            end
            if (do_mark && state_reg[k] != nav_pkg::AV_UNKNOWN) begin
                pend_next[k] = 1'b1;
            end
        end
    end

    // Totals move by the change in the addressed row alone.
    assign w_before  = watch_reg[row];
    assign w_after   = w_before || in_deployed_reg || in_heard_reg;
    assign on_before = w_before && (cur_state == nav_pkg::AV_ONLINE);
    assign on_after  = w_after && (new_state == nav_pkg::AV_ONLINE);

    always_comb begin
        online_next  = online_reg;
        watched_next = watched_reg;
        if (do_eval) begin
            online_next  = online_reg + nav_pkg::TOTAL_W'(on_after)
                           - nav_pkg::TOTAL_W'(on_before);
            watched_next = watched_reg + nav_pkg::TOTAL_W'(w_after && !w_before);
        end
    end

    assign row_state = in_range ? state_next[row] : nav_pkg::AV_UNKNOWN;
    assign row_watch = in_range && watch_next[row];
    assign row_pend  = in_range && pend_next[row];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= nav_pkg::THRESHOLD_RESET;
            online_reg  <= '0;
            watched_reg <= '0;
            for (int k = 0; k < nav_pkg::NODES; k++) begin
                state_reg[k] <= nav_pkg::AV_UNKNOWN;
                seen_reg[k]  <= 1'b0;
                watch_reg[k] <= 1'b0;
                pend_reg[k]  <= 1'b0;
                lfc_reg[k]   <= '0;
            end
        end else begin
            if (cfg_wen) begin
                thr_reg <= cfg_wdata;
            end
            online_reg  <= online_next;
            watched_reg <= watched_next;
            for (int k = 0; k < nav_pkg::NODES; k++) begin
                state_reg[k] <= state_next[k];
                seen_reg[k]  <= seen_next[k];
                watch_reg[k] <= watch_next[k];
                pend_reg[k]  <= pend_next[k];
                lfc_reg[k]   <= lfc_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.exec) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            out_data_reg <= {7'd0,
                             watched_next,
                             online_next,
                             row_pend,
                             row_watch,
                             row_state,
                             changed ? new_state : nav_pkg::AV_UNKNOWN,
                             changed ? cur_state : nav_pkg::AV_UNKNOWN,
                             changed};
        end
    end

endmodule
